@@ hdl/mlptw_pkg.sv @@
// Shared types, codes and the sequencer's control store for the page table walker.
package mlptw_pkg;

	localparam int CMD_W     = 2;
	localparam int VPN_W     = 45;
	localparam int PPN_W     = 52;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam int UPC_W     = 4;
	// Width of the slices that a link value is folded into before frame reduction.
	localparam int CHUNK_W   = 13;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MAP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [VPN_W-1:0] virt_page;
		logic [PPN_W-1:0] phys_page;
	} req_t;

	typedef struct packed {
		logic [PPN_W-1:0] mapped_page;
		logic             hit;
		logic             status;
	} rsp_t;

	typedef struct packed {
		logic             valid;
		logic [PPN_W-1:0] payload;
	} entry_t;

	typedef enum logic [3:0] {
		UOP_CLR_INIT,
		UOP_CLEAR,
		UOP_NEXT_FRAME,
		UOP_IDLE,
		UOP_REDUCE,
		UOP_READ,
		UOP_FOLLOW,
		UOP_NOP,
		UOP_DESCEND,
		UOP_ALLOC,
		UOP_LINK,
		UOP_LEAF,
		UOP_FINISH
	} uop_t;

	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_START,
		COND_SWEEP_MORE,
		COND_FRAME_MORE,
		COND_RED_BUSY,
		COND_FAST,
		COND_LEVEL_ZERO,
		COND_RD_VALID,
		COND_NOT_MAP,
		COND_ALLOC_FAIL
	} cond_t;

	typedef logic [UPC_W-1:0] upc_t;

	// Step addresses of the control program.
	localparam upc_t PC_CLR_INIT  = 4'd0;
	localparam upc_t PC_CLR_LOOP  = 4'd1;
	localparam upc_t PC_CLR_NEXT  = 4'd2;
	localparam upc_t PC_IDLE      = 4'd3;
	localparam upc_t PC_REDUCE    = 4'd4;
	localparam upc_t PC_READ      = 4'd5;
	localparam upc_t PC_STEP      = 4'd6;
	localparam upc_t PC_CHK_LEAF  = 4'd7;
	localparam upc_t PC_DESCEND   = 4'd8;
	localparam upc_t PC_MISS      = 4'd9;
	localparam upc_t PC_ALLOC     = 4'd10;
	localparam upc_t PC_CLR_FRESH = 4'd11;
	localparam upc_t PC_LINK      = 4'd12;
	localparam upc_t PC_LEAF      = 4'd13;
	localparam upc_t PC_FINISH    = 4'd14;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		upc_t  target;
	} uword_t;

	// When the condition holds the sequencer jumps to target, otherwise it steps on.
	function automatic uword_t ucode_rom(upc_t pc);
		uword_t w;
		case (pc)
			PC_CLR_INIT:  w = '{op: UOP_CLR_INIT,   cond: COND_NEVER,      target: PC_CLR_LOOP};
			PC_CLR_LOOP:  w = '{op: UOP_CLEAR,      cond: COND_SWEEP_MORE, target: PC_CLR_LOOP};
			PC_CLR_NEXT:  w = '{op: UOP_NEXT_FRAME, cond: COND_FRAME_MORE, target: PC_CLR_LOOP};
			PC_IDLE:      w = '{op: UOP_IDLE,       cond: COND_NO_START,   target: PC_IDLE};
			PC_REDUCE:    w = '{op: UOP_REDUCE,     cond: COND_RED_BUSY,   target: PC_REDUCE};
			PC_READ:      w = '{op: UOP_READ,       cond: COND_NEVER,      target: PC_STEP};
			PC_STEP:      w = '{op: UOP_FOLLOW,     cond: COND_FAST,       target: PC_READ};
			PC_CHK_LEAF:  w = '{op: UOP_NOP,        cond: COND_LEVEL_ZERO, target: PC_LEAF};
			PC_DESCEND:   w = '{op: UOP_DESCEND,    cond: COND_RD_VALID,   target: PC_REDUCE};
			PC_MISS:      w = '{op: UOP_NOP,        cond: COND_NOT_MAP,    target: PC_FINISH};
			PC_ALLOC:     w = '{op: UOP_ALLOC,      cond: COND_ALLOC_FAIL, target: PC_FINISH};
			PC_CLR_FRESH: w = '{op: UOP_CLEAR,      cond: COND_SWEEP_MORE, target: PC_CLR_FRESH};
			PC_LINK:      w = '{op: UOP_LINK,       cond: COND_ALWAYS,     target: PC_READ};
			PC_LEAF:      w = '{op: UOP_LEAF,       cond: COND_ALWAYS,     target: PC_IDLE};
			PC_FINISH:    w = '{op: UOP_FINISH,     cond: COND_ALWAYS,     target: PC_IDLE};
			default:      w = '{op: UOP_NOP,        cond: COND_ALWAYS,     target: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ hdl/mlptw_store.sv @@
// Frame store: single write port, single registered read port.
module mlptw_store import mlptw_pkg::*; #(
	parameter int ADDR_W = 15,
	parameter int DEPTH  = 32768
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  entry_t            wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output entry_t            rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/mlptw_frame_mod.sv @@
// Reduces a stored link or root value to a frame number modulo the frame count.
module mlptw_frame_mod import mlptw_pkg::*; #(
	parameter int NUM_FRAMES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [PPN_W-1:0]              value,
	output logic                          done,
	output logic [$clog2(NUM_FRAMES)-1:0] frame
);

	localparam int FRAME_W = $clog2(NUM_FRAMES);
	localparam int CHUNKS  = PPN_W / CHUNK_W;
	localparam int SUM_W   = CHUNK_W + FRAME_W + $clog2(CHUNKS);
	localparam int SHIFT   = SUM_W + FRAME_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam longint RECIP = ((longint'(1) << SHIFT) + NUM_FRAMES - 1) / NUM_FRAMES;

	// Residue of 2^(CHUNK_W*i) modulo the frame count.
	function automatic longint chunk_weight(input int i);
		longint w;
		w = 1;
		for (int k = 0; k < i * CHUNK_W; k++) begin
			w = (w * 2) % NUM_FRAMES;
		end
		return w;
	endfunction

	logic             sum_ok_q;
	logic             quo_ok_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] quo_q;
	logic [SUM_W-1:0] term [CHUNKS];
	logic [SUM_W-1:0] fold;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0] rem;
	logic             in_range;

	assign in_range = value < PPN_W'(NUM_FRAMES);

	// Each slice is weighted by its residue, so the sum is congruent to the value.
	for (genvar g = 0; g < CHUNKS; g++) begin : g_fold
		localparam logic [FRAME_W-1:0] WEIGHT = FRAME_W'(chunk_weight(g));
		assign term[g] = SUM_W'(value[g*CHUNK_W +: CHUNK_W]) * SUM_W'(WEIGHT);
	end

	always_comb begin
		fold = '0;
		for (int j = 0; j < CHUNKS; j++) begin
			fold = fold + term[j];
		end
	end

	// Quotient by reciprocal multiplication, exact for every sum below 2^SUM_W.
	assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);
	assign rem  = sum_q - quo_q * SUM_W'(NUM_FRAMES);

	assign done  = en && (quo_ok_q || (!sum_ok_q && in_range));
	assign frame = quo_ok_q ? FRAME_W'(rem) : FRAME_W'(value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_ok_q <= 1'b0;
			quo_ok_q <= 1'b0;
		end else if (en) begin
			sum_ok_q <= !sum_ok_q && !quo_ok_q && !in_range;
			quo_ok_q <= sum_ok_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en && !sum_ok_q && !quo_ok_q) begin
			sum_q <= fold;
		end
		if (en && sum_ok_q) begin
			quo_q <= SUM_W'(prod >> SHIFT);
		end
	end

endmodule

@@ hdl/multilevel_page_table_walker_top.sv @@
// Top level of the multilevel radix page table walker.
//
//  Channel     Signals                                   Direction  Beat taken when
//  ----------  ----------------------------------------  ---------  ----------------------
//  command     start, busy, request (req_t)              in         start && !busy
//  result      done, result (rsp_t)                      out        done (one cycle)
//  config      cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid && cfg_ready
//
// A query or a walk through existing tables spends a read step and a follow step on each
// table level from the start beat to the done beat. Every table that a map allocates adds
// the clearing of the new frame, one entry per cycle through the single write port of the
// frame store. A link value at or above the frame count is reduced in three steps at that
// level. After reset the sequencer clears the whole store, frame by frame, with busy high;
// configuration writes are taken at any time. Results cannot be stalled: done pulses for
// one cycle while result holds the beat.
module multilevel_page_table_walker_top import mlptw_pkg::*; #(
	parameter int NUM_FRAMES = 64,
	parameter int LEVELS     = 5,
	parameter int INDEX_BITS = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 request,
	output logic                 done,
	output rsp_t                 result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int FRAME_W = $clog2(NUM_FRAMES);
	localparam int ADDR_W  = FRAME_W + INDEX_BITS;
	localparam int DEPTH   = NUM_FRAMES << INDEX_BITS;
	localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int EXT_W   = LEVELS * INDEX_BITS + VPN_W;
	localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
	localparam int NX_W    = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
	localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(NUM_FRAMES - 1);
	localparam logic [LVL_W-1:0]   TOP_LEVEL  = LVL_W'(LEVELS - 1);

	// Sequencer state and configuration.
	upc_t               upc_q;
	upc_t               upc_d;
	uword_t             cw;
	logic               jump;
	logic [CFG_W-1:0]   root_q;
	logic [CFG_W-1:0]   first_free_q;
	logic [CNT_W-1:0]   alloc_cnt_q;
	logic               done_q;

	// Datapath registers.
	logic [CMD_W-1:0]      cmd_q;
	logic [VPN_W-1:0]      vpn_q;
	logic [PPN_W-1:0]      ppn_q;
	logic [FRAME_W-1:0]    frame_q;
	logic [LVL_W-1:0]      level_q;
	logic [INDEX_BITS-1:0] sweep_q;
	logic [ADDR_W-1:0]     slot_q;
	logic [PPN_W-1:0]      link_q;
	logic                  fail_q;
	rsp_t                  result_q;

	// Datapath logic.
	logic [EXT_W-1:0]      vpn_ext;
	logic [INDEX_BITS-1:0] level_idx;
	logic [ADDR_W-1:0]     rd_addr;
	entry_t                rd_data;
	logic                  re;
	logic                  we;
	logic [ADDR_W-1:0]     waddr;
	entry_t                wdata;
	logic                  link_fast;
	logic                  fast;
	logic [NX_W-1:0]       alloc_next;
	logic                  alloc_fail;
	logic                  leaf_hit;
	logic                  red_done;
	logic [FRAME_W-1:0]    red_frame;

	assign cw        = ucode_rom(upc_q);
	assign busy      = cw.op != UOP_IDLE;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	// The index for the current level; the top level uses the highest slice.
	assign vpn_ext   = EXT_W'(vpn_q);
	assign level_idx = INDEX_BITS'(vpn_ext >> (level_q * INDEX_BITS));
	assign rd_addr   = {frame_q, level_idx};

	// A valid link that already names a frame can be followed without reduction.
	assign link_fast = rd_data.payload < PPN_W'(NUM_FRAMES);
	assign fast      = (level_q != '0) && rd_data.valid && link_fast;

	assign alloc_next = NX_W'(first_free_q) + NX_W'(alloc_cnt_q);
	assign alloc_fail = alloc_next >= NX_W'(NUM_FRAMES);
	assign leaf_hit   = (cmd_q == CMD_QUERY) && rd_data.valid;

	mlptw_store #(
		.ADDR_W (ADDR_W),
		.DEPTH  (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	mlptw_frame_mod #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_frame_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (cw.op == UOP_REDUCE),
		.value  (link_q),
		.done   (red_done),
		.frame  (red_frame)
	);

	// Jump condition of the current control word.
	always_comb begin
		case (cw.cond)
			COND_NEVER:      jump = 1'b0;
			COND_ALWAYS:     jump = 1'b1;
			COND_NO_START:   jump = !start;
			COND_SWEEP_MORE: jump = sweep_q != '1;
			COND_FRAME_MORE: jump = frame_q != LAST_FRAME;
			COND_RED_BUSY:   jump = !red_done;
			COND_FAST:       jump = fast;
			COND_LEVEL_ZERO: jump = level_q == '0;
			COND_RD_VALID:   jump = rd_data.valid;
			COND_NOT_MAP:    jump = cmd_q != CMD_MAP;
			COND_ALLOC_FAIL: jump = alloc_fail;
			default:         jump = 1'b0;
		endcase
		upc_d = jump ? cw.target : upc_q + 1'b1;
	end

	// Store write port: clearing sweeps, table links and leaf updates.
	always_comb begin
		re    = cw.op == UOP_READ;
		we    = 1'b0;
		waddr = {frame_q, sweep_q};
		wdata = '0;
		case (cw.op)
			UOP_CLEAR: begin
				we = 1'b1;
			end
			UOP_LINK: begin
				we    = 1'b1;
				waddr = slot_q;
				wdata = '{valid: 1'b1, payload: PPN_W'(frame_q)};
			end
			UOP_LEAF: begin
				waddr = slot_q;
				if (cmd_q == CMD_MAP) begin
					we    = 1'b1;
					wdata = '{valid: 1'b1, payload: ppn_q};
				end else if (cmd_q == CMD_UNMAP) begin
					we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q        <= PC_CLR_INIT;
			root_q       <= '0;
			first_free_q <= CFG_W'(1);
			alloc_cnt_q  <= '0;
			done_q       <= 1'b0;
		end else begin
			upc_q  <= upc_d;
			done_q <= (cw.op == UOP_LEAF) || (cw.op == UOP_FINISH);
			if (cw.op == UOP_ALLOC && !alloc_fail && alloc_cnt_q < CNT_W'(NUM_FRAMES)) begin
				alloc_cnt_q <= alloc_cnt_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ROOT_FRAME: root_q       <= cfg_data;
					CFG_FIRST_FREE: first_free_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cw.op)
			UOP_CLR_INIT: begin
				frame_q <= '0;
				sweep_q <= '0;
			end
			UOP_CLEAR: begin
				sweep_q <= sweep_q + 1'b1;
			end
			UOP_NEXT_FRAME: begin
				frame_q <= frame_q + 1'b1;
			end
			UOP_IDLE: begin
				if (start) begin
					cmd_q   <= request.command;
					vpn_q   <= request.virt_page;
					ppn_q   <= request.phys_page;
					link_q  <= PPN_W'(root_q);
					level_q <= TOP_LEVEL;
					fail_q  <= 1'b0;
				end
			end
			UOP_REDUCE: begin
				if (red_done) begin
					frame_q <= red_frame;
				end
			end
			UOP_READ: begin
				slot_q <= rd_addr;
			end
			UOP_FOLLOW: begin
				// A link that needs reduction is parked in link_q for the reduce step.
				if (level_q != '0 && rd_data.valid) begin
					link_q <= rd_data.payload;
					if (link_fast) begin
						frame_q <= FRAME_W'(rd_data.payload);
						level_q <= level_q - 1'b1;
					end
				end
			end
			UOP_DESCEND: begin
				level_q <= level_q - 1'b1;
			end
			UOP_ALLOC: begin
				if (alloc_fail) begin
					fail_q <= 1'b1;
				end else begin
					frame_q <= FRAME_W'(alloc_next);
					sweep_q <= '0;
				end
			end
			UOP_LEAF: begin
				result_q <= '{mapped_page: leaf_hit ? rd_data.payload : '0,
					hit: leaf_hit, status: 1'b0};
			end
			UOP_FINISH: begin
				result_q <= '{mapped_page: '0, hit: 1'b0, status: fail_q};
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/mlptw_checker.sv @@
// Port-level checks for the page table walker and their binding to the top level.
module mlptw_checker import mlptw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t result
);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while the walker is still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not make the walker busy");

	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (result.status == 1'b0))
		else $error("hit reported together with a failed status");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.mapped_page == '0))
		else $error("nonzero page returned without a hit");

endmodule

bind multilevel_page_table_walker_top mlptw_checker u_mlptw_checker (.*);
